@@ hw/rtl/ud_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared constants and the record type passed from the front end to the queue.
// ----------------------------------------------------------------------------
package ud_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

    // Partial payload before the final trail byte: at most 3 + 6 + 6 bits
    localparam int unsigned PART_W = CP_W - 6;

    // One queue entry: the results caused by one input item.
    // two = 1: a flagged U+FFFD goes out first, then cp/bad.
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp;
        logic            bad;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);

endpackage

@@ hw/rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Turns a byte stream into Unicode code points, one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte per transfer in s_tdata; a transfer with s_tlast
//   high marks end of text, its byte is ignored and any unfinished sequence
//   is flushed as a flagged U+FFFD.
//   Master channel: one code point per transfer in m_tdata, m_tuser high when
//   the result replaces bad input (U+FFFD), m_tlast high on the final result
//   caused by one input transfer. An ASCII or invalid byte inside a sequence gives
//   two results: a flagged U+FFFD and then the byte's own decode.
//   A result passes through the record queue and the output register before it reaches the master side.
//   Throughput: one byte per cycle while the queue has room; a byte that gives
//   two results holds the output register for both, which the record queue
//   (FIFO_DEPTH entries) absorbs while input keeps flowing.
//   Reset (synchronous, active low) clears the pending sequence, the queue and
//   the output register. When the receiver stalls, the output holds, the
//   queue fills, and s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import ud_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] byte_in
    input  logic        i_s_tlast,    // end_of_text
    // Code point output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // [20:0] codepoint, [23:21] zero
    output logic [0:0]  o_m_tuser,    // [0] malformed
    output logic        o_m_tlast     // last result of this input transfer
);

    logic            take;
    logic            push;
    t_rec            rec;
    logic            full;
    logic            empty;
    t_rec            head;
    logic            pop;
    logic [CP_W-1:0] cp;
    logic            bad;

    // Accept whenever the queue has room for the record this byte may make
    assign o_s_tready = !full;
    assign take       = i_s_tvalid && !full;

    ud_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_s_tdata),
        .i_eot   (i_s_tlast),
        .o_push  (push),
        .o_rec   (rec)
    );

    ud_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ud_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cp    (cp),
        .o_bad   (bad),
        .o_last  (o_m_tlast)
    );

    // Pad the code point to whole bytes
    assign o_m_tdata = {3'b000, cp};
    assign o_m_tuser = bad;

endmodule

@@ hw/rtl/ud_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Classifies each byte, holds the partial sequence and builds result records.
// ----------------------------------------------------------------------------
module ud_front import ud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output logic       o_push,
    output t_rec       o_rec
);

    logic [1:0]        r_rem;
    logic [PART_W-1:0] r_part;
    logic [1:0]        n_rem;
    logic [PART_W-1:0] n_part;

    logic              pending;
    logic              is_trail;
    logic [CP_W-1:0]   full_cp;
    logic              cp_ok;
    logic              push;

    logic              lead_push;
    logic [CP_W-1:0]   lead_cp;
    logic              lead_bad;
    logic [1:0]        lead_rem;
    logic [PART_W-1:0] lead_part;

    assign pending  = (r_rem != 2'd0);
    assign is_trail = (i_byte[7:6] == 2'b10);
    assign full_cp  = {r_part, i_byte[5:0]};
    assign cp_ok    = (full_cp <= MAX_CP) && !((full_cp >= SURR_LO) && (full_cp <= SURR_HI));

    // Lead byte decode
    always_comb begin
        lead_push = 1'b0;
        lead_cp   = REPL_CP;
        lead_bad  = 1'b1;
        lead_rem  = 2'd0;
        lead_part = '0;
        if (i_byte[7] == 1'b0) begin
            lead_push = 1'b1;
            lead_cp   = {{(CP_W-8){1'b0}}, i_byte};
            lead_bad  = 1'b0;
        end else if (i_byte[7:5] == 3'b110) begin
            lead_rem  = 2'd1;
            lead_part = {{(PART_W-5){1'b0}}, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_rem  = 2'd2;
            lead_part = {{(PART_W-4){1'b0}}, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_rem  = 2'd3;
            lead_part = {{(PART_W-3){1'b0}}, i_byte[2:0]};
        end else begin
            lead_push = 1'b1;
        end
    end

    always_comb begin
        n_rem  = r_rem;
        n_part = r_part;
        push   = 1'b0;
        o_rec  = '{two: 1'b0, cp: REPL_CP, bad: 1'b1};
        if (i_eot) begin
            // Flush a pending partial sequence
            push   = pending;
            n_rem  = 2'd0;
            n_part = '0;
        end else if (pending && is_trail) begin
            n_rem  = r_rem - 2'd1;
            n_part = full_cp[PART_W-1:0];
            if (r_rem == 2'd1) begin
                push      = 1'b1;
                o_rec.cp  = cp_ok ? full_cp : REPL_CP;
                o_rec.bad = !cp_ok;
                n_part    = '0;
            end
        end else begin
            n_rem  = lead_rem;
            n_part = lead_part;
            if (pending) begin
                // Abort the sequence, then decode this byte afresh
                push      = 1'b1;
                o_rec.two = lead_push;
                o_rec.cp  = lead_push ? lead_cp : REPL_CP;
                o_rec.bad = lead_push ? lead_bad : 1'b1;
            end else begin
                push      = lead_push;
                o_rec.cp  = lead_cp;
                o_rec.bad = lead_bad;
            end
        end
    end

    assign o_push = i_take && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 2'd0;
            r_part <= '0;
        end else if (i_take) begin
            r_rem  <= n_rem;
            r_part <= n_part;
        end
    end

endmodule

@@ hw/rtl/ud_fifo.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder record queue
// Short FIFO of result records between the front end and the output stage.
// ----------------------------------------------------------------------------
module ud_fifo import ud_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_rec o_head
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/ud_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Splits each record into one or two results and holds them for the receiver.
// ----------------------------------------------------------------------------
module ud_back import ud_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_rec            i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_cp,
    output logic            o_bad,
    output logic            o_last
);

    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_bad;
    logic            r_last;
    logic            r_second;   // first half of a two-result record already sent
    logic            load;
    logic            first_half;

    assign load       = (!r_valid || i_ready) && !i_empty;
    assign first_half = i_head.two && !r_second;
    assign o_pop      = load && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= first_half;
        end else if (i_ready) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_half) begin
                r_cp   <= REPL_CP;
                r_bad  <= 1'b1;
                r_last <= 1'b0;
            end else begin
                r_cp   <= i_head.cp;
                r_bad  <= i_head.bad;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cp    = r_cp;
    assign o_bad   = r_bad;
    assign o_last  = r_last;

endmodule

@@ dv/tb_utf8_stream_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends a byte stream into the decoder and checks every code point it returns.
// The text starts with a short hand-written part and goes on with random
// characters, broken sequences, stray bytes and end-of-text marks. A local
// decoder predicts the results of each accepted byte. The sender works in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
    import ud_pkg::*;

    localparam int RAND_BYTES  = 750;      // random part of the text, in bytes
    localparam int HOLD_AT     = 400;      // bytes sent before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       hold;      // wait until every expected code point is in
    } text_item_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            last;
    } cp_rec_t;

    typedef enum logic [1:0] {
        SINK_FREE,             // always ready
        SINK_COIN,             // ready half of the time
        SINK_SLOW,             // ready a quarter of the time
        SINK_BUSY              // ready most of the time
    } sink_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    text_item_t text_bytes[$];
    cp_rec_t    pending_cps[$];

    // Local decoder state
    logic [1:0]      trail_left = 2'd0;
    logic [CP_W-1:0] acc_bits = '0;

    int mismatches = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int mode_left = 0;
    sink_mode_t sink_mode = SINK_FREE;
    bit pause_next = 1'b0;

    utf8_stream_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [7:0] byte_in
        .i_s_tlast  (i_s_tlast),    // end_of_text
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [20:0] codepoint, [23:21] zero
        .o_m_tuser  (o_m_tuser),    // [0] malformed
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the local decoder by one accepted byte and queue what it yields
    task automatic decode_utf8_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] res_cp[2];
        logic            res_bad[2];
        logic [CP_W-1:0] v;
        cp_rec_t         rec;
        int              n;
        n = 0;
        if (eot) begin
            // Flush an unfinished sequence; nothing comes out when idle
            if (trail_left != 2'd0) begin
                res_cp[n] = REPL_CP; res_bad[n] = 1'b1; n++;
            end
            trail_left = 2'd0;
            acc_bits = '0;
        end else if (trail_left != 2'd0 && b[7:6] == 2'b10) begin
            acc_bits = {acc_bits[CP_W-7:0], b[5:0]};
            trail_left = trail_left - 2'd1;
            if (trail_left == 2'd0) begin
                v = acc_bits;
                if (v > MAX_CP || (v >= SURR_LO && v <= SURR_HI)) begin
                    res_cp[n] = REPL_CP; res_bad[n] = 1'b1;
                end else begin
                    res_cp[n] = v; res_bad[n] = 1'b0;
                end
                n++;
                acc_bits = '0;
            end
        end else begin
            // A non-trail byte cuts a pending sequence short, then starts afresh
            if (trail_left != 2'd0) begin
                res_cp[n] = REPL_CP; res_bad[n] = 1'b1; n++;
                trail_left = 2'd0;
                acc_bits = '0;
            end
            casez (b)
                8'b0???????: begin
                    res_cp[n] = {{(CP_W-8){1'b0}}, b}; res_bad[n] = 1'b0; n++;
                end
                8'b110?????: begin
                    acc_bits = {{(CP_W-5){1'b0}}, b[4:0]}; trail_left = 2'd1;
                end
                8'b1110????: begin
                    acc_bits = {{(CP_W-4){1'b0}}, b[3:0]}; trail_left = 2'd2;
                end
                8'b11110???: begin
                    acc_bits = {{(CP_W-3){1'b0}}, b[2:0]}; trail_left = 2'd3;
                end
                default: begin
                    res_cp[n] = REPL_CP; res_bad[n] = 1'b1; n++;
                end
            endcase
        end
        for (int k = 0; k < n; k++) begin
            rec.cp   = res_cp[k];
            rec.bad  = res_bad[k];
            rec.last = (k == n - 1);
            pending_cps.push_back(rec);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        text_item_t it;
        it.b    = b;
        it.eot  = eot;
        it.hold = pause_next;
        pause_next = 1'b0;
        text_bytes.push_back(it);
    endtask

    // Encode v in len bytes (overlong and out-of-range forms allowed) and
    // queue the first nb of them
    task automatic queue_seq(input logic [CP_W-1:0] v, input int len, input int nb);
        logic [7:0] seq[4];
        case (len)
            1: seq[0] = {1'b0, v[6:0]};
            2: begin
                seq[0] = {3'b110, v[10:6]};
                seq[1] = {2'b10, v[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, v[15:12]};
                seq[1] = {2'b10, v[11:6]};
                seq[2] = {2'b10, v[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, v[20:18]};
                seq[1] = {2'b10, v[17:12]};
                seq[2] = {2'b10, v[11:6]};
                seq[3] = {2'b10, v[5:0]};
            end
        endcase
        for (int k = 0; k < nb; k++)
            queue_byte(seq[k], 1'b0);
    endtask

    // Source: offer queued bytes in bursts, predict each accepted transfer
    always @(posedge i_clk) begin : source_p
        text_item_t nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_utf8_byte(i_s_tdata, i_s_tlast);
                bytes_sent++;
            end
            // Hold the current byte until it is taken
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (text_bytes.size() != 0 &&
                             !(text_bytes[0].hold && pending_cps.size() != 0)) begin
                    nxt = text_bytes.pop_front();
                    i_s_tdata  <= nxt.b;
                    i_s_tlast  <= nxt.eot;
                    i_s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: change stall pattern now and then; one long hold-off mid-run
    always @(posedge i_clk) begin : sink_p
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (sink_mode)
                SINK_FREE: i_m_tready <= 1'b1;
                SINK_COIN: i_m_tready <= 1'($urandom_range(0, 1));
                SINK_SLOW: i_m_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Monitor: compare each code point transfer with the oldest prediction
    always @(posedge i_clk) begin : check_p
        cp_rec_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_cps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got cp %h bad %b last %b",
                         $time, o_m_tdata[20:0], o_m_tuser[0], o_m_tlast);
            end else begin
                want = pending_cps.pop_front();
                if (o_m_tdata[20:0] !== want.cp) begin
                    mismatches++;
                    $display("%0t: codepoint: expected %h, got %h",
                             $time, want.cp, o_m_tdata[20:0]);
                end
                if (o_m_tdata[23:21] !== 3'b000) begin
                    mismatches++;
                    $display("%0t: tdata padding: expected 000, got %b",
                             $time, o_m_tdata[23:21]);
                end
                if (o_m_tuser[0] !== want.bad) begin
                    mismatches++;
                    $display("%0t: malformed: expected %b, got %b",
                             $time, want.bad, o_m_tuser[0]);
                end
                if (o_m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: last: expected %b, got %b",
                             $time, want.last, o_m_tlast);
                end
            end
        end
    end

    initial begin : run_p
        int pick;
        int len;
        int target;
        // Directed text: byte extremes, each length, range limits, stray and
        // invalid bytes, cut-short sequences and end of text in both states
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_seq(21'h000080, 2, 2);
        queue_seq(REPL_CP, 3, 3);              // well-formed U+FFFD, not flagged
        queue_seq(SURR_LO, 3, 3);              // surrogate
        queue_seq(MAX_CP, 4, 4);
        queue_seq(21'h1FFFFF, 4, 4);           // beyond the code space
        queue_byte(8'h80, 1'b0);               // trail byte with nothing pending
        queue_byte(8'hF8, 1'b0);               // invalid lead
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h41, 1'b0);               // ASCII cuts the sequence: two results
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hE9, 1'b0);               // lead cuts the sequence, starts its own
        queue_byte(8'h5A, 1'b1);               // flush the pending sequence
        queue_byte(8'hA5, 1'b1);               // end of text while idle
        pause_next = 1'b1;
        target = text_bytes.size() + RAND_BYTES;

        // Random text: mostly well-formed characters of random length and content
        while (text_bytes.size() < target) begin
            if ($urandom_range(0, 59) == 0)
                pause_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                len = $urandom_range(1, 4);
                queue_seq(CP_W'($urandom), len, len);
            end else if (pick < 74) begin
                queue_seq(SURR_LO | CP_W'($urandom & 32'h7FF), 3, 3);
            end else if (pick < 78) begin
                queue_seq($urandom_range(0, 1) ? MAX_CP : MAX_CP + 21'd1, 4, 4);
            end else if (pick < 87) begin
                len = $urandom_range(2, 4);
                queue_seq(CP_W'($urandom), len, $urandom_range(1, len - 1));
            end else if (pick < 96) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        queue_byte(8'($urandom_range(0, 255)), 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (pending_cps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_cps.size() == 0)
            $display("utf8_stream_decoder regression: pass");
        else
            $display("utf8_stream_decoder regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog_p
        #400000;
        $display("utf8_stream_decoder regression: fail");
        $finish;
    end

endmodule
